### rtl/gtc_pkg.sv
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared widths, types, register indexes and fixed-point helpers for the
// gammatone channel with ratemap.
// ----------------------------------------------------------------------------
package gtc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAME_MAX   = 4096;
    localparam int POS_W       = $clog2(FRAME_MAX);
    localparam int LEN_W       = POS_W + 1;

    localparam int OPW    = 64;
    localparam int PRODW  = 128;
    localparam int WIDEW  = 130;
    localparam int DIG_W  = 16;
    localparam int DIGITS = OPW / DIG_W;
    localparam int CNT_W  = $clog2(DIGITS);

    localparam int RAD_W  = 96;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SQC_W  = $clog2(ROOT_W);

    typedef logic signed [OPW-1:0]   operand_t;
    typedef logic signed [PRODW-1:0] product_t;
    typedef logic signed [WIDEW-1:0] wide_t;

    localparam logic [2:0] REG_POLE_RADIUS    = 3'd0;
    localparam logic [2:0] REG_PHASE_COS      = 3'd1;
    localparam logic [2:0] REG_PHASE_SIN      = 3'd2;
    localparam logic [2:0] REG_GAIN_LEFT      = 3'd3;
    localparam logic [2:0] REG_GAIN_RIGHT     = 3'd4;
    localparam logic [2:0] REG_ENVELOPE_DECAY = 3'd5;
    localparam logic [2:0] REG_FRAME_LENGTH   = 3'd6;
    localparam logic [2:0] REG_FRAME_SCALE    = 3'd7;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic [12:0] FRAME_LENGTH_RESET = 13'd160;

    // Add half an LSB, then shift right arithmetically by k.
    function automatic product_t round_shift(product_t v, int unsigned k);
        product_t half;
        half = product_t'(1) <<< (k - 1);
        return (v + half) >>> k;
    endfunction

    function automatic wide_t widen(product_t v);
        return wide_t'(v);
    endfunction

    function automatic logic signed [63:0] sat_s(wide_t v, int unsigned bits);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
        lo = -(wide_t'(1) <<< (bits - 1));
        if (v > hi) begin
            return hi[63:0];
        end
        if (v < lo) begin
            return lo[63:0];
        end
        return v[63:0];
    endfunction

    function automatic logic [63:0] sat_u(wide_t v, int unsigned bits);
        wide_t hi;
        hi = (wide_t'(1) <<< bits) - wide_t'(1);
        if (v < wide_t'(0)) begin
            return 64'd0;
        end
        if (v > hi) begin
            return hi[63:0];
        end
        return v[63:0];
    endfunction

    function automatic operand_t sx48(logic signed [47:0] v);
        return {{16{v[47]}}, v};
    endfunction

    function automatic operand_t sx32(logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

### rtl/gtc_mul.sv
// ----------------------------------------------------------------------------
// gtc_mul
// Shared signed 64 x 64 multiplier, one 16-bit digit of the second operand
// per cycle on the magnitudes, sign applied to the finished product.
// ----------------------------------------------------------------------------
module gtc_mul
    import gtc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  operand_t op_a,
    input  operand_t op_b,
    output logic     busy,
    output logic     done,
    output product_t product
);

    logic [OPW-1:0]   mag_a_reg, mag_a_next;
    logic [OPW-1:0]   mag_b_reg, mag_b_next;
    logic             neg_reg, neg_next;
    logic [PRODW-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIG_W-1:0]       digit;
    logic [OPW+DIG_W-1:0]   partial;
    logic [PRODW-1:0]       shifted;
    logic [CNT_W+3:0]       base;

    assign base    = {cnt_reg, 4'b0000};
    assign digit   = mag_b_reg[base +: DIG_W];
    assign partial = mag_a_reg * digit;
    assign shifted = {{(PRODW-OPW-DIG_W){1'b0}}, partial} << base;

    always_comb
    begin
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            mag_a_next = op_a[OPW-1] ? (~op_a + 1'b1) : op_a;
            mag_b_next = op_b[OPW-1] ? (~op_b + 1'b1) : op_b;
            neg_next   = op_a[OPW-1] ^ op_b[OPW-1];
            acc_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + shifted;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = neg_reg ? (~acc_reg + 1'b1) : acc_reg;

endmodule

### rtl/gtc_sqrt.sv
// ----------------------------------------------------------------------------
// gtc_sqrt
// Floor square root, restoring method, one result bit per cycle.
// ----------------------------------------------------------------------------
module gtc_sqrt
    import gtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]  src_reg, src_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SQC_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;

    assign rem_sh = {rem_reg[ROOT_W-1:0], src_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_comb
    begin
        src_next  = src_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            src_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            src_next = src_reg << 2;
            cnt_next = cnt_reg + 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == SQC_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/gammatone_channel_ratemap.sv
// ----------------------------------------------------------------------------
// gammatone_channel_ratemap
// One channel of a fourth-order complex gammatone filter with per-side
// envelope integration and frame ratemap, run by a sequencer around one
// shared multiplier and one square-root unit.
// Per sample the sequencer runs 33 multiplies on the shared multiplier, a
// square root, a sum step and an output step, then returns to idle; a new
// sample is taken only in idle, so samples do not overlap.
// A finished result waits in the output register while the next sample runs.
// Reset (rst_n, asynchronous, active low) restores register defaults,
// clears taps, envelopes, frame sums and position, and sets the phasor to one.
// ----------------------------------------------------------------------------
module gammatone_channel_ratemap
    import gtc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            bm_left,
    output logic signed [31:0]            bm_right,
    output logic                          frame_done,
    output logic [31:0]                   rate_left,
    output logic [31:0]                   rate_right
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_POST  = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [5:0] SQ_A2   = 6'd0;
    localparam logic [5:0] SQ_A3   = 6'd1;
    localparam logic [5:0] SQ_A4   = 6'd2;
    localparam logic [5:0] SQ_RMIX = 6'd3;
    localparam logic [5:0] SQ_RT0  = 6'd4;
    localparam logic [5:0] SQ_RT1  = 6'd5;
    localparam logic [5:0] SQ_RT2  = 6'd6;
    localparam logic [5:0] SQ_RT3  = 6'd7;
    localparam logic [5:0] SQ_RZ0  = 6'd8;
    localparam logic [5:0] SQ_RZ1  = 6'd9;
    localparam logic [5:0] SQ_IMIX = 6'd10;
    localparam logic [5:0] SQ_IT0  = 6'd11;
    localparam logic [5:0] SQ_IT1  = 6'd12;
    localparam logic [5:0] SQ_IT2  = 6'd13;
    localparam logic [5:0] SQ_IT3  = 6'd14;
    localparam logic [5:0] SQ_IZ0  = 6'd15;
    localparam logic [5:0] SQ_IZ1  = 6'd16;
    localparam logic [5:0] SQ_DR   = 6'd17;
    localparam logic [5:0] SQ_DI   = 6'd18;
    localparam logic [5:0] SQ_BML  = 6'd19;
    localparam logic [5:0] SQ_BMR  = 6'd20;
    localparam logic [5:0] SQ_SQR  = 6'd21;
    localparam logic [5:0] SQ_SQI  = 6'd22;
    localparam logic [5:0] SQ_EML  = 6'd23;
    localparam logic [5:0] SQ_EDL  = 6'd24;
    localparam logic [5:0] SQ_EMR  = 6'd25;
    localparam logic [5:0] SQ_EDR  = 6'd26;
    localparam logic [5:0] SQ_RTL  = 6'd27;
    localparam logic [5:0] SQ_RTR  = 6'd28;
    localparam logic [5:0] SQ_PCC  = 6'd29;
    localparam logic [5:0] SQ_PCS  = 6'd30;
    localparam logic [5:0] SQ_PSC  = 6'd31;
    localparam logic [5:0] SQ_PSS  = 6'd32;

    // Configuration registers
    logic [29:0]        pole_radius_reg, pole_radius_next;
    logic signed [31:0] phase_cos_reg, phase_cos_next;
    logic signed [31:0] phase_sin_reg, phase_sin_next;
    logic [31:0]        gain_left_reg, gain_left_next;
    logic [31:0]        gain_right_reg, gain_right_next;
    logic [29:0]        envelope_decay_reg, envelope_decay_next;
    logic [12:0]        frame_length_reg, frame_length_next;
    logic [31:0]        frame_scale_reg, frame_scale_next;

    // Control and filter state
    logic [2:0]         state_reg, state_next;
    logic [5:0]         step_reg, step_next;
    logic signed [47:0] rt_reg [4];
    logic signed [47:0] rt_next [4];
    logic signed [47:0] it_reg [4];
    logic signed [47:0] it_next [4];
    logic signed [31:0] pc_reg, pc_next;
    logic signed [31:0] ps_reg, ps_next;
    logic [47:0]        envl_reg, envl_next;
    logic [47:0]        envr_reg, envr_next;
    logic [59:0]        suml_reg, suml_next;
    logic [59:0]        sumr_reg, sumr_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;

    // Working values
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [30:0]        a2_reg, a2_next;
    logic [30:0]        a3_reg, a3_next;
    logic [30:0]        a4_reg, a4_next;
    logic signed [65:0] tmp_reg, tmp_next;
    logic signed [47:0] ur_reg, ur_next;
    logic signed [47:0] ui_reg, ui_next;
    logic signed [47:0] d_reg, d_next;
    logic signed [31:0] bml_reg, bml_next;
    logic signed [31:0] bmr_reg, bmr_next;
    logic [47:0]        mag_reg, mag_next;
    logic               fdone_reg, fdone_next;
    logic [31:0]        ratel_reg, ratel_next;
    logic [31:0]        rater_reg, rater_next;
    product_t           acc_reg, acc_next;
    logic signed [31:0] pcn_reg, pcn_next;
    logic signed [31:0] bm_left_reg, bm_left_next;
    logic signed [31:0] bm_right_reg, bm_right_next;
    logic               frame_done_reg, frame_done_next;
    logic [31:0]        rate_left_reg, rate_left_next;
    logic [31:0]        rate_right_reg, rate_right_next;

    // Shared units
    logic     mul_start;
    logic     mul_busy;
    logic     mul_done;
    product_t mul_product;
    operand_t op_a;
    operand_t op_b;
    logic     acc_clr;
    logic     sqrt_start;
    logic     sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    logic     cfg_write;
    logic     in_fire;
    operand_t c0, c1, c2, c3, c4;
    operand_t a_x, a2_x, a3_x, a4_x;
    product_t r16, r30, r31;
    wide_t    w_tmp, w_r16, w_r30, w_r31;
    logic signed [63:0] sat_v;
    logic [63:0]        usat_v;
    logic [60:0]        sum_l, sum_r;
    logic [LEN_W-1:0]   frame_len;
    logic [LEN_W-1:0]   pos_inc;

    gtc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_product)
    );

    gtc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg[RAD_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign mul_start = (state_reg == S_ISSUE);

    // Recursion coefficients from the pole radius and its rounded powers.
    assign a_x  = {34'd0, pole_radius_reg};
    assign a2_x = {33'd0, a2_reg};
    assign a3_x = {33'd0, a3_reg};
    assign a4_x = {33'd0, a4_reg};
    assign c0   = a_x <<< 2;
    assign c1   = -((a2_x <<< 2) + (a2_x <<< 1));
    assign c2   = a3_x <<< 2;
    assign c3   = -a4_x;
    assign c4   = a2_x;

    assign r16   = round_shift(acc_reg, 16);
    assign r30   = round_shift(acc_reg, 30);
    assign r31   = round_shift(acc_reg, 31);
    assign w_r16 = widen(r16);
    assign w_r30 = widen(r30);
    assign w_r31 = widen(r31);
    assign w_tmp = {{(WIDEW-66){tmp_reg[65]}}, tmp_reg};

    assign sum_l = {1'b0, suml_reg} + {13'd0, envl_reg};
    assign sum_r = {1'b0, sumr_reg} + {13'd0, envr_reg};

    always_comb
    begin
        if (frame_length_reg == 13'd0)
        begin
            frame_len = LEN_W'(1);
        end
        else if (32'(frame_length_reg) > 32'(FRAME_MAX))
        begin
            frame_len = LEN_W'(FRAME_MAX);
        end
        else
        begin
            frame_len = LEN_W'(frame_length_reg);
        end
    end

    assign pos_inc = {1'b0, pos_reg} + 1'b1;

    // Operand selection for each sequencer step.
    always_comb
    begin
        op_a    = '0;
        op_b    = '0;
        acc_clr = 1'b1;
        case (step_reg)
            SQ_A2:   begin op_a = a_x;  op_b = a_x; end
            SQ_A3:   begin op_a = a2_x; op_b = a_x; end
            SQ_A4:   begin op_a = a3_x; op_b = a_x; end
            SQ_RMIX: begin op_a = sx32(pc_reg) <<< 6;
                           op_b = operand_t'(sample_reg); end
            SQ_RT0:  begin op_a = c0; op_b = sx48(rt_reg[0]); acc_clr = 1'b0; end
            SQ_RT1:  begin op_a = c1; op_b = sx48(rt_reg[1]); acc_clr = 1'b0; end
            SQ_RT2:  begin op_a = c2; op_b = sx48(rt_reg[2]); acc_clr = 1'b0; end
            SQ_RT3:  begin op_a = c3; op_b = sx48(rt_reg[3]); acc_clr = 1'b0; end
            SQ_RZ0:  begin op_a = c0; op_b = sx48(rt_reg[0]); end
            SQ_RZ1:  begin op_a = c4; op_b = sx48(rt_reg[1]); acc_clr = 1'b0; end
            SQ_IMIX: begin op_a = sx32(ps_reg) <<< 6;
                           op_b = operand_t'(sample_reg); end
            SQ_IT0:  begin op_a = c0; op_b = sx48(it_reg[0]); acc_clr = 1'b0; end
            SQ_IT1:  begin op_a = c1; op_b = sx48(it_reg[1]); acc_clr = 1'b0; end
            SQ_IT2:  begin op_a = c2; op_b = sx48(it_reg[2]); acc_clr = 1'b0; end
            SQ_IT3:  begin op_a = c3; op_b = sx48(it_reg[3]); acc_clr = 1'b0; end
            SQ_IZ0:  begin op_a = c0; op_b = sx48(it_reg[0]); end
            SQ_IZ1:  begin op_a = c4; op_b = sx48(it_reg[1]); acc_clr = 1'b0; end
            SQ_DR:   begin op_a = sx48(ur_reg); op_b = sx32(pc_reg); end
            SQ_DI:   begin op_a = sx48(ui_reg); op_b = sx32(ps_reg); acc_clr = 1'b0; end
            SQ_BML:  begin op_a = sx48(d_reg); op_b = {32'd0, gain_left_reg}; end
            SQ_BMR:  begin op_a = sx48(d_reg); op_b = {32'd0, gain_right_reg}; end
            SQ_SQR:  begin op_a = sx48(ur_reg); op_b = sx48(ur_reg); end
            SQ_SQI:  begin op_a = sx48(ui_reg); op_b = sx48(ui_reg); acc_clr = 1'b0; end
            SQ_EML:  begin op_a = {16'd0, mag_reg}; op_b = {32'd0, gain_left_reg}; end
            SQ_EDL:  begin op_a = {34'd0, envelope_decay_reg}; op_b = {16'd0, envl_reg}; end
            SQ_EMR:  begin op_a = {16'd0, mag_reg}; op_b = {32'd0, gain_right_reg}; end
            SQ_EDR:  begin op_a = {34'd0, envelope_decay_reg}; op_b = {16'd0, envr_reg}; end
            SQ_RTL:  begin op_a = {4'd0, suml_reg}; op_b = {32'd0, frame_scale_reg}; end
            SQ_RTR:  begin op_a = {4'd0, sumr_reg}; op_b = {32'd0, frame_scale_reg}; end
            SQ_PCC:  begin op_a = sx32(phase_cos_reg); op_b = sx32(pc_reg); end
            SQ_PCS:  begin op_a = sx32(phase_sin_reg); op_b = sx32(ps_reg); acc_clr = 1'b0; end
            SQ_PSC:  begin op_a = sx32(phase_cos_reg); op_b = sx32(ps_reg); end
            SQ_PSS:  begin op_a = -sx32(phase_sin_reg); op_b = sx32(pc_reg); acc_clr = 1'b0; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb
    begin
        pole_radius_next    = pole_radius_reg;
        phase_cos_next      = phase_cos_reg;
        phase_sin_next      = phase_sin_reg;
        gain_left_next      = gain_left_reg;
        gain_right_next     = gain_right_reg;
        envelope_decay_next = envelope_decay_reg;
        frame_length_next   = frame_length_reg;
        frame_scale_next    = frame_scale_reg;

        state_next      = state_reg;
        step_next       = step_reg;
        rt_next         = rt_reg;
        it_next         = it_reg;
        pc_next         = pc_reg;
        ps_next         = ps_reg;
        envl_next       = envl_reg;
        envr_next       = envr_reg;
        suml_next       = suml_reg;
        sumr_next       = sumr_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg & ~out_ready;

        sample_next     = sample_reg;
        a2_next         = a2_reg;
        a3_next         = a3_reg;
        a4_next         = a4_reg;
        tmp_next        = tmp_reg;
        ur_next         = ur_reg;
        ui_next         = ui_reg;
        d_next          = d_reg;
        bml_next        = bml_reg;
        bmr_next        = bmr_reg;
        mag_next        = mag_reg;
        fdone_next      = fdone_reg;
        ratel_next      = ratel_reg;
        rater_next      = rater_reg;
        acc_next        = acc_reg;
        pcn_next        = pcn_reg;
        bm_left_next    = bm_left_reg;
        bm_right_next   = bm_right_reg;
        frame_done_next = frame_done_reg;
        rate_left_next  = rate_left_reg;
        rate_right_next = rate_right_reg;

        sqrt_start = 1'b0;
        sat_v      = '0;
        usat_v     = '0;

        if (cfg_write)
        begin
            case (paddr[4:2])
                REG_POLE_RADIUS:    pole_radius_next    = pwdata[29:0];
                REG_PHASE_COS:      phase_cos_next      = pwdata;
                REG_PHASE_SIN:      phase_sin_next      = pwdata;
                REG_GAIN_LEFT:      gain_left_next      = pwdata;
                REG_GAIN_RIGHT:     gain_right_next     = pwdata;
                REG_ENVELOPE_DECAY: envelope_decay_next = pwdata[29:0];
                REG_FRAME_LENGTH:   frame_length_next   = pwdata[12:0];
                REG_FRAME_SCALE:    frame_scale_next    = pwdata;
                default:            pole_radius_next    = pole_radius_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample;
                    step_next   = SQ_A2;
                    state_next  = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    acc_next   = (acc_clr ? product_t'(0) : acc_reg) + mul_product;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                step_next  = step_reg + 1'b1;
                state_next = S_ISSUE;
                case (step_reg)
                    SQ_A2: a2_next = r30[30:0];
                    SQ_A3: a3_next = r30[30:0];
                    SQ_A4: a4_next = r30[30:0];
                    SQ_RT3, SQ_IT3:
                    begin
                        // First pole section output, kept for the zero section.
                        sat_v    = sat_s(w_r30, 48);
                        tmp_next = {{2{sat_v[63]}}, sat_v};
                    end
                    SQ_RZ1:
                    begin
                        sat_v      = sat_s(w_tmp + w_r30, 48);
                        ur_next    = sat_v[47:0];
                        rt_next[3] = rt_reg[2];
                        rt_next[2] = rt_reg[1];
                        rt_next[1] = rt_reg[0];
                        rt_next[0] = tmp_reg[47:0];
                    end
                    SQ_IZ1:
                    begin
                        sat_v      = sat_s(w_tmp + w_r30, 48);
                        ui_next    = sat_v[47:0];
                        it_next[3] = it_reg[2];
                        it_next[2] = it_reg[1];
                        it_next[1] = it_reg[0];
                        it_next[0] = tmp_reg[47:0];
                    end
                    SQ_DI:
                    begin
                        sat_v  = sat_s(w_r30, 48);
                        d_next = sat_v[47:0];
                    end
                    SQ_BML:
                    begin
                        sat_v    = sat_s(w_r16, 32);
                        bml_next = sat_v[31:0];
                    end
                    SQ_BMR:
                    begin
                        sat_v    = sat_s(w_r16, 32);
                        bmr_next = sat_v[31:0];
                    end
                    SQ_SQI:
                    begin
                        sqrt_start = 1'b1;
                        state_next = S_SQRT;
                    end
                    SQ_EML, SQ_EMR:
                    begin
                        tmp_next = r16[65:0];
                    end
                    SQ_EDL:
                    begin
                        usat_v    = sat_u(w_tmp + w_r30, 48);
                        envl_next = usat_v[47:0];
                    end
                    SQ_EDR:
                    begin
                        usat_v     = sat_u(w_tmp + w_r30, 48);
                        envr_next  = usat_v[47:0];
                        state_next = S_SUM;
                    end
                    SQ_RTL:
                    begin
                        usat_v     = sat_u(w_r31, 32);
                        ratel_next = (usat_v[31:0] == 32'd0) ? 32'd1 : usat_v[31:0];
                    end
                    SQ_RTR:
                    begin
                        usat_v     = sat_u(w_r31, 32);
                        rater_next = (usat_v[31:0] == 32'd0) ? 32'd1 : usat_v[31:0];
                    end
                    SQ_PCS:
                    begin
                        sat_v    = sat_s(w_r30, 32);
                        pcn_next = sat_v[31:0];
                    end
                    SQ_PSS:
                    begin
                        sat_v      = sat_s(w_r30, 32);
                        ps_next    = sat_v[31:0];
                        pc_next    = pcn_reg;
                        state_next = S_DONE;
                        if (fdone_reg)
                        begin
                            suml_next = '0;
                            sumr_next = '0;
                            pos_next  = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_ISSUE;
                    end
                endcase
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    mag_next   = sqrt_root;
                    state_next = S_ISSUE;
                end
            end
            S_SUM:
            begin
                suml_next  = sum_l[60] ? {60{1'b1}} : sum_l[59:0];
                sumr_next  = sum_r[60] ? {60{1'b1}} : sum_r[59:0];
                fdone_next = (pos_inc >= frame_len);
                state_next = S_ISSUE;
            end
            S_DONE:
            begin
                // Hold here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    bm_left_next    = bml_reg;
                    bm_right_next   = bmr_reg;
                    frame_done_next = fdone_reg;
                    rate_left_next  = fdone_reg ? ratel_reg : 32'd0;
                    rate_right_next = fdone_reg ? rater_reg : 32'd0;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_radius_reg    <= '0;
            phase_cos_reg      <= ONE_Q30;
            phase_sin_reg      <= '0;
            gain_left_reg      <= '0;
            gain_right_reg     <= '0;
            envelope_decay_reg <= '0;
            frame_length_reg   <= FRAME_LENGTH_RESET;
            frame_scale_reg    <= '0;
            state_reg          <= S_IDLE;
            step_reg           <= SQ_A2;
            for (int i = 0; i < 4; i++)
            begin
                rt_reg[i] <= '0;
                it_reg[i] <= '0;
            end
            pc_reg        <= ONE_Q30;
            ps_reg        <= '0;
            envl_reg      <= '0;
            envr_reg      <= '0;
            suml_reg      <= '0;
            sumr_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pole_radius_reg    <= pole_radius_next;
            phase_cos_reg      <= phase_cos_next;
            phase_sin_reg      <= phase_sin_next;
            gain_left_reg      <= gain_left_next;
            gain_right_reg     <= gain_right_next;
            envelope_decay_reg <= envelope_decay_next;
            frame_length_reg   <= frame_length_next;
            frame_scale_reg    <= frame_scale_next;
            state_reg          <= state_next;
            step_reg           <= step_next;
            rt_reg             <= rt_next;
            it_reg             <= it_next;
            pc_reg             <= pc_next;
            ps_reg             <= ps_next;
            envl_reg           <= envl_next;
            envr_reg           <= envr_next;
            suml_reg           <= suml_next;
            sumr_reg           <= sumr_next;
            pos_reg            <= pos_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        a2_reg         <= a2_next;
        a3_reg         <= a3_next;
        a4_reg         <= a4_next;
        tmp_reg        <= tmp_next;
        ur_reg         <= ur_next;
        ui_reg         <= ui_next;
        d_reg          <= d_next;
        bml_reg        <= bml_next;
        bmr_reg        <= bmr_next;
        mag_reg        <= mag_next;
        fdone_reg      <= fdone_next;
        ratel_reg      <= ratel_next;
        rater_reg      <= rater_next;
        acc_reg        <= acc_next;
        pcn_reg        <= pcn_next;
        bm_left_reg    <= bm_left_next;
        bm_right_reg   <= bm_right_next;
        frame_done_reg <= frame_done_next;
        rate_left_reg  <= rate_left_next;
        rate_right_reg <= rate_right_next;
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_POLE_RADIUS:    prdata = {2'd0, pole_radius_reg};
            REG_PHASE_COS:      prdata = phase_cos_reg;
            REG_PHASE_SIN:      prdata = phase_sin_reg;
            REG_GAIN_LEFT:      prdata = gain_left_reg;
            REG_GAIN_RIGHT:     prdata = gain_right_reg;
            REG_ENVELOPE_DECAY: prdata = {2'd0, envelope_decay_reg};
            REG_FRAME_LENGTH:   prdata = {19'd0, frame_length_reg};
            REG_FRAME_SCALE:    prdata = frame_scale_reg;
            default:            prdata = 32'd0;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign bm_left    = bm_left_reg;
    assign bm_right   = bm_right_reg;
    assign frame_done = frame_done_reg;
    assign rate_left  = rate_left_reg;
    assign rate_right = rate_right_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_ISSUE)
        else $error("accepted sample did not start the sequencer");

    a_mul_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier restarted while busy");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == S_MUL)
        else $error("product returned outside the multiply wait");

    a_rate_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> rate_left != 32'd0 && rate_right != 32'd0)
        else $error("frame closed with a zero rate");

    a_rate_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> rate_left == 32'd0 && rate_right == 32'd0)
        else $error("rate reported on a beat that closes no frame");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for one gammatone ratemap channel. Samples go through a
// valid/ready driver; every result beat is compared field by field against a
// bit-exact fixed-point model of the channel kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import gtc_pkg::*;

    typedef logic signed [129:0] acc_t;

    typedef struct {
        logic signed [31:0] bm_l;
        logic signed [31:0] bm_r;
        logic               done;
        logic [31:0]        rate_l;
        logic [31:0]        rate_r;
    } ratemap_beat_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [4:0]                    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [31:0]            bm_left;
    logic signed [31:0]            bm_right;
    logic                          frame_done;
    logic [31:0]                   rate_left;
    logic [31:0]                   rate_right;

    gammatone_channel_ratemap dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .bm_left(bm_left), .bm_right(bm_right), .frame_done(frame_done),
        .rate_left(rate_left), .rate_right(rate_right)
    );

    // Model copy of the configuration registers.
    logic [29:0]        m_radius;
    logic signed [31:0] m_step_cos;
    logic signed [31:0] m_step_sin;
    logic [31:0]        m_gain_l;
    logic [31:0]        m_gain_r;
    logic [29:0]        m_decay;
    logic [12:0]        m_frame_len;
    logic [31:0]        m_frame_scale;

    // Model copy of the channel state.
    logic signed [47:0] taps [2][4];
    logic signed [31:0] rot_cos;
    logic signed [31:0] rot_sin;
    logic [47:0]        env_l;
    logic [47:0]        env_r;
    logic [59:0]        sum_l;
    logic [59:0]        sum_r;
    int unsigned        frame_pos;

    logic signed [SAMPLE_BITS-1:0] sample_queue[$];
    ratemap_beat_t                 pending_beats[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic long_stall_go = 1'b0;
    logic long_stall_used = 1'b0;
    int  long_stall_left = 0;
    int  errors = 0;
    int  beats_checked = 0;
    int  frames_seen = 0;
    int  samples_sent = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic acc_t rnd_shift(acc_t v, int k);
        return (v + (acc_t'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic acc_t clip_signed(acc_t v, int bits);
        acc_t top;
        top = (acc_t'(1) <<< (bits - 1));
        if (v >= top) return top - 1;
        if (v < -top) return -top;
        return v;
    endfunction

    function automatic acc_t clip_unsigned(acc_t v, int bits);
        acc_t top;
        top = (acc_t'(1) <<< bits) - 1;
        if (v < 0) return 0;
        if (v > top) return top;
        return v;
    endfunction

    function automatic acc_t floor_root(acc_t s);
        acc_t m;
        acc_t c;
        m = 0;
        for (int b = 48; b >= 0; b--) begin
            c = m | (acc_t'(1) <<< b);
            if (c * c <= s) m = c;
        end
        return m;
    endfunction

    function automatic logic [31:0] frame_rate(logic [59:0] s);
        acc_t sv;
        acc_t sc;
        acc_t r;
        sv = s;
        sc = m_frame_scale;
        r = clip_unsigned(rnd_shift(sv * sc, 31), 32);
        return (r == 0) ? 32'd1 : r[31:0];
    endfunction

    function automatic void reset_channel_model();
        m_radius = 0; m_step_cos = ONE_Q30; m_step_sin = 0;
        m_gain_l = 0; m_gain_r = 0; m_decay = 0;
        m_frame_len = FRAME_LENGTH_RESET; m_frame_scale = 0;
        for (int r = 0; r < 2; r++)
            for (int i = 0; i < 4; i++) taps[r][i] = 0;
        rot_cos = ONE_Q30; rot_sin = 0;
        env_l = 0; env_r = 0; sum_l = 0; sum_r = 0; frame_pos = 0;
    endfunction

    // Advances the channel model by one sample and returns the beat it makes.
    function automatic ratemap_beat_t channel_step(logic signed [SAMPLE_BITS-1:0] s_in);
        ratemap_beat_t res;
        acc_t a, a2, a3, a4, s, pc, ps, sc, ss, acc, p0, d, mag, t, gl, gr, dec, e;
        acc_t coef[5];
        acc_t mix[2];
        acc_t outp[2];
        int unsigned len;
        a = m_radius;
        s = s_in;
        pc = rot_cos;
        ps = rot_sin;
        a2 = rnd_shift(a * a, 30);
        a3 = rnd_shift(a2 * a, 30);
        a4 = rnd_shift(a3 * a, 30);
        coef[0] = 4 * a; coef[1] = -6 * a2; coef[2] = 4 * a3; coef[3] = -a4; coef[4] = a2;
        mix[0] = pc * s * 64;
        mix[1] = ps * s * 64;
        for (int r = 0; r < 2; r++) begin
            acc = mix[r];
            for (int i = 0; i < 4; i++) acc = acc + coef[i] * acc_t'(taps[r][i]);
            p0 = clip_signed(rnd_shift(acc, 30), 48);
            acc = coef[0] * acc_t'(taps[r][0]) + coef[4] * acc_t'(taps[r][1]);
            outp[r] = clip_signed(p0 + rnd_shift(acc, 30), 48);
            taps[r][3] = taps[r][2]; taps[r][2] = taps[r][1]; taps[r][1] = taps[r][0];
            taps[r][0] = p0[47:0];
        end
        d = clip_signed(rnd_shift(outp[0] * pc + outp[1] * ps, 30), 48);
        gl = m_gain_l;
        gr = m_gain_r;
        t = clip_signed(rnd_shift(d * gl, 16), 32);
        res.bm_l = t[31:0];
        t = clip_signed(rnd_shift(d * gr, 16), 32);
        res.bm_r = t[31:0];

        mag = floor_root(outp[0] * outp[0] + outp[1] * outp[1]);
        dec = m_decay;
        e = env_l;
        t = clip_unsigned(rnd_shift(mag * gl, 16) + rnd_shift(dec * e, 30), 48);
        env_l = t[47:0];
        e = env_r;
        t = clip_unsigned(rnd_shift(mag * gr, 16) + rnd_shift(dec * e, 30), 48);
        env_r = t[47:0];
        t = clip_unsigned(acc_t'(sum_l) + acc_t'(env_l), 60);
        sum_l = t[59:0];
        t = clip_unsigned(acc_t'(sum_r) + acc_t'(env_r), 60);
        sum_r = t[59:0];

        len = (m_frame_len == 0) ? 1 : ((m_frame_len > FRAME_MAX) ? FRAME_MAX : m_frame_len);
        if (frame_pos + 1 >= len) begin
            res.done = 1'b1;
            res.rate_l = frame_rate(sum_l);
            res.rate_r = frame_rate(sum_r);
            sum_l = 0; sum_r = 0; frame_pos = 0;
        end else begin
            res.done = 1'b0; res.rate_l = 0; res.rate_r = 0;
            frame_pos++;
        end

        sc = m_step_cos;
        ss = m_step_sin;
        t = clip_signed(rnd_shift(sc * pc + ss * ps, 30), 32);
        rot_cos = t[31:0];
        t = clip_signed(rnd_shift(sc * ps - ss * pc, 30), 32);
        rot_sin = t[31:0];
        return res;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_POLE_RADIUS:    m_radius = value[29:0];
            REG_PHASE_COS:      m_step_cos = value;
            REG_PHASE_SIN:      m_step_sin = value;
            REG_GAIN_LEFT:      m_gain_l = value;
            REG_GAIN_RIGHT:     m_gain_r = value;
            REG_ENVELOPE_DECAY: m_decay = value[29:0];
            REG_FRAME_LENGTH:   m_frame_len = value[12:0];
            REG_FRAME_SCALE:    m_frame_scale = value;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [29:0] radius, logic signed [31:0] c, logic signed [31:0] s,
                             logic [31:0] gl, logic [31:0] gr, logic [29:0] decay,
                             logic [12:0] flen, logic [31:0] fscale);
        write_reg(REG_POLE_RADIUS, {2'b00, radius});
        write_reg(REG_PHASE_COS, c);
        write_reg(REG_PHASE_SIN, s);
        write_reg(REG_GAIN_LEFT, gl);
        write_reg(REG_GAIN_RIGHT, gr);
        write_reg(REG_ENVELOPE_DECAY, {2'b00, decay});
        write_reg(REG_FRAME_LENGTH, {19'd0, flen});
        write_reg(REG_FRAME_SCALE, fscale);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (sample_queue.size() != 0 || in_valid || pending_beats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            2: return $signed(16'($urandom_range(200))) - 16'sd100;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Sample driver.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                pending_beats.push_back(channel_step(sample));
                samples_sent++;
            end
            if (!in_valid || in_ready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    sample <= sample_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the block backs up onto its input.
    always @(posedge clk) begin
        if (long_stall_go && !long_stall_used) begin
            long_stall_left <= 4000;
            long_stall_used <= 1'b1;
        end else if (long_stall_left > 0) begin
            long_stall_left <= long_stall_left - 1;
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n) begin
        ratemap_beat_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (pending_beats.size() == 0) begin
                    $display("%0t: unexpected result beat bm_left=%h", $time, bm_left);
                    errors++;
                end else begin
                    want = pending_beats.pop_front();
                    beats_checked++;
                    if (frame_done) frames_seen++;
                    if (bm_left !== want.bm_l) begin
                        $display("%0t: bm_left exp %h got %h", $time, want.bm_l, bm_left);
                        errors++;
                    end
                    if (bm_right !== want.bm_r) begin
                        $display("%0t: bm_right exp %h got %h", $time, want.bm_r, bm_right);
                        errors++;
                    end
                    if (frame_done !== want.done) begin
                        $display("%0t: frame_done exp %b got %b", $time, want.done, frame_done);
                        errors++;
                    end
                    if (rate_left !== want.rate_l) begin
                        $display("%0t: rate_left exp %h got %h", $time, want.rate_l, rate_left);
                        errors++;
                    end
                    if (rate_right !== want.rate_r) begin
                        $display("%0t: rate_right exp %h got %h", $time, want.rate_r, rate_right);
                        errors++;
                    end
                end
            end
            out_ready <= (long_stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #60_000_000;
        $display("Run timed out after %0d checked beats.", beats_checked);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        real ang;
        int  n_items;
        logic signed [SAMPLE_BITS-1:0] directed[] = '{16'sh7fff, 16'sh8000, 0, 1, -1,
            16'sh5555, 16'shaaaa, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
            16'sh0100, -16'sh0100, 0, 0, 0, 16'sh4000, 16'shc000};

        reset_channel_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: moderate filter, short frames, edge samples and padding.
        write_all(30'd966367642, 32'sd759250125, 32'sd759250125, 32'h0100_0000,
                  32'h0080_0000, 30'd536870912, 13'd3, 32'h2000_0000);
        foreach (directed[i]) sample_queue.push_back(directed[i]);
        wait_drained();

        // Everything at its limit: saturating filter and phasor, length zero.
        write_all(30'h3fff_ffff, -32'sh4000_0000, 32'sh4000_0000, 32'hffff_ffff,
                  32'hffff_ffff, 30'h3fff_ffff, 13'd0, 32'h8000_0000);
        for (int i = 0; i < 24; i++) sample_queue.push_back(i[0] ? 16'sh8000 : 16'sh7fff);
        wait_drained();

        // Zero radius, gain and scale: rates fall to the one-LSB floor.
        write_all(30'd0, 32'sh4000_0000, 32'sd0, 32'd0, 32'd0, 30'd0, 13'd2, 32'd0);
        for (int i = 0; i < 8; i++) sample_queue.push_back(random_sample());
        wait_drained();

        for (int ph = 0; ph < 7; ph++) begin
            send_idle_pct = (ph < 2) ? 20 : ((ph < 4) ? 76 : 0);
            recv_idle_pct = (ph < 2) ? 76 : ((ph < 4) ? 20 : 0);
            ang = ($urandom_range(10000) / 10000.0) * 3.14159265;
            write_all(30'($urandom_range(32'h3fff_ffff, 32'h3000_0000)),
                      $rtoi($cos(ang) * 1073741824.0), $rtoi($sin(ang) * 1073741824.0),
                      $urandom_range(32'h0400_0000), $urandom_range(32'h0400_0000),
                      30'($urandom_range(32'h3fff_ffff)), 13'($urandom_range(40, 1)),
                      $urandom_range(32'h8000_0000));
            if (ph == 5) write_reg(REG_FRAME_LENGTH, 32'd4096);
            if (ph == 6) write_reg(REG_FRAME_LENGTH, 32'd8191);
            n_items = (ph == 5 || ph == 6) ? 150 : 280;
            for (int i = 0; i < n_items; i++) sample_queue.push_back(random_sample());
            if (ph == 2) long_stall_go <= 1'b1;
            wait_drained();
            // Shorten the frame mid-way so the open frame closes early.
            if (ph == 1) begin
                write_reg(REG_FRAME_LENGTH, 32'd1);
                for (int i = 0; i < 10; i++) sample_queue.push_back(random_sample());
                wait_drained();
            end
        end

        repeat (400) @(posedge clk);
        $display("Checked %0d beats from %0d samples, %0d frame closes,", beats_checked,
                 samples_sent, frames_seen);
        $display("over extreme, floor-rate and random filter settings with stalls.");
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d beats missing.", errors, pending_beats.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
